// ----- hw/rtl/imars_pkg.sv -----
`timescale 1ns / 1ps

package imars_pkg;

  // Widest time and count values that any build of the block carries.
  localparam int TIME_W_MAX = 40;
  localparam int CNT_W_MAX  = 32;

  // Accumulator widths.
  localparam int SUM_BITS = 48;
  localparam int SQ_BITS  = 64;

  // Shared divider: dividend and divisor widths.
  localparam int DVD_BITS = 64;
  localparam int DVS_BITS = 33;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_OFFSET = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ZERO_SUB     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MISSION      = 2'd2;

  localparam logic [31:0] MISSION_RESET = 32'd86400;

  // Configuration register file contents.
  typedef struct packed {
    logic [31:0] start_offset;
    logic [15:0] zero_sub;
    logic [31:0] mission_seconds;
  } cfg_t;

  // Statistics of one finished run, handed from the front to the back.
  typedef struct packed {
    logic [CNT_W_MAX-1:0]  count;
    logic [TIME_W_MAX-1:0] earliest;
    logic [TIME_W_MAX-1:0] dur_lo;
    logic [TIME_W_MAX-1:0] dur_hi;
    logic [SUM_BITS-1:0]   dur_total;
    logic [TIME_W_MAX-1:0] space_lo;
    logic [TIME_W_MAX-1:0] space_hi;
    logic [SUM_BITS-1:0]   space_total;
    logic [SQ_BITS-1:0]    sq_total;
  } snap_t;

  // Divider request and response.
  typedef struct packed {
    logic                start;
    logic [DVD_BITS-1:0] dividend;
    logic [DVS_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [DVD_BITS-1:0] quotient;
  } div_rsp_t;

  // Clamp a wide value into a 32-bit result field.
  function automatic logic [31:0] sat32(input logic [63:0] v);
    return (|v[63:32]) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

endpackage

// ----- hw/rtl/imars_in_if.sv -----
`timescale 1ns / 1ps

// Channel that carries access intervals into the block.
interface imars_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] interval_start;
  logic [31:0] interval_end;
  logic        last_of_target;

  modport source(output valid, output interval_start, output interval_end,
                 output last_of_target, input ready);
  modport sink(input valid, input interval_start, input interval_end,
               input last_of_target, output ready);
endinterface

// ----- hw/rtl/imars_out_if.sv -----
`timescale 1ns / 1ps

// Channel that carries the statistics of one finished run.
interface imars_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] merged_count;
  logic [31:0] coverage_delay;
  logic [31:0] access_min;
  logic [31:0] access_max;
  logic [31:0] access_mean;
  logic        revisited;
  logic [31:0] gap_min;
  logic [31:0] gap_max;
  logic [31:0] gap_mean;
  logic [31:0] response_mean;

  modport source(output valid, output merged_count, output coverage_delay,
                 output access_min, output access_max, output access_mean,
                 output revisited, output gap_min, output gap_max,
                 output gap_mean, output response_mean, input ready);
  modport sink(input valid, input merged_count, input coverage_delay,
               input access_min, input access_max, input access_mean,
               input revisited, input gap_min, input gap_max,
               input gap_mean, input response_mean, output ready);
endinterface

// ----- hw/rtl/imars_cfg_if.sv -----
`timescale 1ns / 1ps

// Register write channel.
interface imars_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/interval_merge_access_revisit_stats_unit.sv -----
`timescale 1ns / 1ps

// Channel     Direction  Payload
// intervals   in         interval_start, interval_end, last_of_target
// stats       out        merged_count .. response_mean, one per run
// cfg         in         index, data (register write)
//
// An item that extends or opens an interval passes only the merge state of the
// front; one that closes an interval also passes the close, square and accumulate
// states, and the last item of a run ends with the hand-over into the two-entry run queue.
// The back runs one 64-step divider: one division for the access mean, and two
// more divisions when the run has a revisit.
// Reset is synchronous; there is no clearing pass.
// The front keeps accepting a following run while the back divides; it stalls
// only when both queue entries are taken. A waiting result holds the back only.
module interval_merge_access_revisit_stats_unit #(
  parameter int TIME_BITS  = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  imars_in_if.sink    intervals,
  imars_out_if.source stats,
  imars_cfg_if.sink   cfg
);
  import imars_pkg::*;

  cfg_t     cfg_regs;
  snap_t    push_data;
  snap_t    pop_data;
  logic     push;
  logic     pop;
  logic     full;
  logic     empty;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Register writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.start_offset    <= '0;
      cfg_regs.zero_sub        <= '0;
      cfg_regs.mission_seconds <= MISSION_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_START_OFFSET: cfg_regs.start_offset    <= cfg.data;
        REG_ZERO_SUB:     cfg_regs.zero_sub        <= cfg.data[15:0];
        REG_MISSION:      cfg_regs.mission_seconds <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // Merge and accumulate.
  imars_front #(
    .TIME_BITS (TIME_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .intervals(intervals),
    .cfg      (cfg_regs),
    .snap     (push_data),
    .push     (push),
    .full     (full)
  );

  // Finished runs waiting for the back.
  imars_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (full),
    .pop      (pop),
    .pop_data (pop_data),
    .empty    (empty)
  );

  // Shared divider.
  imars_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  // Means and the result register.
  imars_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_regs),
    .pop_data(pop_data),
    .empty   (empty),
    .pop     (pop),
    .div_req (div_req),
    .div_rsp (div_rsp),
    .stats   (stats)
  );

endmodule

// ----- hw/rtl/imars_front.sv -----
`timescale 1ns / 1ps

module imars_front #(
  parameter int TIME_BITS  = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  imars_in_if.sink         intervals,
  input  imars_pkg::cfg_t  cfg,
  output imars_pkg::snap_t snap,
  output logic             push,
  input  logic             full
);
  import imars_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MERGE  = 3'd1;
  localparam logic [2:0] ST_CLOSE  = 3'd2;
  localparam logic [2:0] ST_SQUARE = 3'd3;
  localparam logic [2:0] ST_ACC    = 3'd4;
  localparam logic [2:0] ST_PUSH   = 3'd5;

  logic [2:0] state;

  // Latched item.
  logic [TIME_BITS-1:0] item_start;
  logic [TIME_BITS-1:0] item_end;
  logic                 item_last;
  logic                 reopen;

  // Run state.
  logic [TIME_BITS-1:0]  open_begin;
  logic [TIME_BITS-1:0]  open_finish;
  logic                  have_open;
  logic [COUNT_BITS-1:0] closed_count;
  logic [TIME_BITS-1:0]  earliest_start;
  logic [TIME_BITS-1:0]  prev_close;
  logic [TIME_BITS-1:0]  dur_lo;
  logic [TIME_BITS-1:0]  dur_hi;
  logic [SUM_BITS-1:0]   dur_total;
  logic [TIME_BITS-1:0]  space_lo;
  logic [TIME_BITS-1:0]  space_hi;
  logic [SUM_BITS-1:0]   space_total;
  logic [SQ_BITS-1:0]    space_sq_total;

  // Values of the interval being closed.
  logic [TIME_BITS-1:0] dur_r;
  logic [TIME_BITS-1:0] gap_r;
  logic                 has_gap;
  logic [SQ_BITS-1:0]   sq_r;

  logic                 accept;
  logic [TIME_BITS-1:0] s_in;
  logic [TIME_BITS-1:0] e_in;
  logic [TIME_BITS-1:0] dur_raw;
  logic [TIME_BITS-1:0] dur_c;
  logic [TIME_BITS-1:0] gap_c;
  logic [63:0]          gap_wide;
  logic [31:0]          gap_lo;
  logic [63:0]          gap_prod;
  logic [SQ_BITS-1:0]   sq_c;
  logic [SUM_BITS:0]    dur_sum;
  logic [SUM_BITS:0]    space_sum;
  logic [SQ_BITS:0]     sq_sum;

  // The front takes an item only between sequencer passes.
  assign intervals.ready = (state == ST_IDLE);
  assign accept          = intervals.valid && intervals.ready;
  assign push            = (state == ST_PUSH) && !full;

  // Inputs reduced to the time width; an end before the start is the start.
  assign s_in = TIME_BITS'(intervals.interval_start);
  assign e_in = TIME_BITS'(intervals.interval_end);

  // Duration and gap of the open interval as it closes.
  assign dur_raw = open_finish - open_begin;
  assign dur_c   = (dur_raw == '0) ? TIME_BITS'(cfg.zero_sub) : dur_raw;
  assign gap_c   = (open_begin > prev_close) ? open_begin - prev_close : '0;

  // Square of the gap; a gap wider than 32 bits saturates.
  assign gap_wide = 64'(gap_r);
  assign gap_lo   = gap_wide[31:0];
  assign gap_prod = gap_lo * gap_lo;
  assign sq_c     = (|gap_wide[63:32]) ? '1 : gap_prod;

  // Saturating accumulations.
  assign dur_sum   = {1'b0, dur_total} + (SUM_BITS + 1)'(dur_r);
  assign space_sum = {1'b0, space_total} + (SUM_BITS + 1)'(gap_r);
  assign sq_sum    = {1'b0, space_sq_total} + {1'b0, sq_r};

  // Sequencer and run state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      reopen         <= 1'b0;
      have_open      <= 1'b0;
      closed_count   <= '0;
      dur_lo         <= '1;
      dur_hi         <= '0;
      dur_total      <= '0;
      space_lo       <= '1;
      space_hi       <= '0;
      space_total    <= '0;
      space_sq_total <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_MERGE;
          end
        end
        ST_MERGE: begin
          if (!have_open) begin
            if (closed_count == '0) begin
              earliest_start <= item_start;
            end
            open_begin  <= item_start;
            open_finish <= item_end;
            have_open   <= 1'b1;
            state       <= item_last ? ST_CLOSE : ST_IDLE;
          end else if (open_finish < item_start) begin
            reopen <= 1'b1;
            state  <= ST_CLOSE;
          end else begin
            if (open_finish < item_end) begin
              open_finish <= item_end;
            end
            state <= item_last ? ST_CLOSE : ST_IDLE;
          end
        end
        ST_CLOSE: begin
          state <= ST_SQUARE;
        end
        ST_SQUARE: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          if (dur_r < dur_lo) begin
            dur_lo <= dur_r;
          end
          if (dur_r > dur_hi) begin
            dur_hi <= dur_r;
          end
          dur_total <= dur_sum[SUM_BITS] ? '1 : dur_sum[SUM_BITS-1:0];
          if (has_gap) begin
            if (gap_r < space_lo) begin
              space_lo <= gap_r;
            end
            if (gap_r > space_hi) begin
              space_hi <= gap_r;
            end
            space_total    <= space_sum[SUM_BITS] ? '1 : space_sum[SUM_BITS-1:0];
            space_sq_total <= sq_sum[SQ_BITS] ? '1 : sq_sum[SQ_BITS-1:0];
          end
          if (closed_count != '1) begin
            closed_count <= closed_count + 1'b1;
          end
          prev_close <= open_finish;
          if (reopen) begin
            open_begin  <= item_start;
            open_finish <= item_end;
            have_open   <= 1'b1;
            reopen      <= 1'b0;
            state       <= item_last ? ST_CLOSE : ST_IDLE;
          end else begin
            have_open <= 1'b0;
            state     <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (push) begin
            have_open      <= 1'b0;
            closed_count   <= '0;
            dur_lo         <= '1;
            dur_hi         <= '0;
            dur_total      <= '0;
            space_lo       <= '1;
            space_hi       <= '0;
            space_total    <= '0;
            space_sq_total <= '0;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Item latch and close values; these carry data only.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_start <= s_in;
      item_end   <= (e_in < s_in) ? s_in : e_in;
      item_last  <= intervals.last_of_target;
    end
    if (state == ST_CLOSE) begin
      dur_r   <= dur_c;
      gap_r   <= gap_c;
      has_gap <= (closed_count != '0);
    end
    if (state == ST_SQUARE) begin
      sq_r <= sq_c;
    end
  end

  // Snapshot of the finished run.
  always_comb begin
    snap.count       = CNT_W_MAX'(closed_count);
    snap.earliest    = TIME_W_MAX'(earliest_start);
    snap.dur_lo      = TIME_W_MAX'(dur_lo);
    snap.dur_hi      = TIME_W_MAX'(dur_hi);
    snap.dur_total   = dur_total;
    snap.space_lo    = TIME_W_MAX'(space_lo);
    snap.space_hi    = TIME_W_MAX'(space_hi);
    snap.space_total = space_total;
    snap.sq_total    = space_sq_total;
  end

  // A run is handed over only when the queue has room.
  a_push_room: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("front pushed into a full queue");

  // Every handed-over run holds at least one merged interval.
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    push |-> closed_count != '0)
    else $error("front pushed an empty run");

  // The run state is cleared once a run has been handed over.
  a_push_clear: assert property (@(posedge clk) disable iff (rst)
    push |=> (closed_count == '0) && !have_open && (dur_total == '0))
    else $error("run state not cleared after hand-over");

endmodule

// ----- hw/rtl/imars_fifo.sv -----
`timescale 1ns / 1ps

module imars_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  imars_pkg::snap_t push_data,
  output logic             full,
  input  logic             pop,
  output imars_pkg::snap_t pop_data,
  output logic             empty
);
  import imars_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  snap_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;

  assign full     = (fill == (PTR_W + 1)'(QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = mem[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/imars_div.sv -----
`timescale 1ns / 1ps

module imars_div (
  input  logic                clk,
  input  logic                rst,
  input  imars_pkg::div_req_t req,
  output imars_pkg::div_rsp_t rsp
);
  import imars_pkg::*;

  localparam int STEP_W = $clog2(DVD_BITS + 1);

  logic                busy;
  logic                done;
  logic [STEP_W-1:0]   steps;
  logic [DVD_BITS-1:0] quo;
  logic [DVS_BITS-1:0] rem;
  logic [DVS_BITS-1:0] dvs;
  logic [DVS_BITS:0]   trial;
  logic [DVS_BITS:0]   diff;
  logic                fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign trial = {rem, quo[DVD_BITS-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = (trial >= {1'b0, dvs});

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (!busy && req.start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DVD_BITS);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the quotient bits shift in where the dividend shifts out.
  always_ff @(posedge clk) begin
    if (!busy && req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= {quo[DVD_BITS-2:0], fits};
      rem <= fits ? diff[DVS_BITS-1:0] : trial[DVS_BITS-1:0];
    end
  end

endmodule

// ----- hw/rtl/imars_back.sv -----
`timescale 1ns / 1ps

module imars_back (
  input  logic                clk,
  input  logic                rst,
  input  imars_pkg::cfg_t     cfg,
  input  imars_pkg::snap_t    pop_data,
  input  logic                empty,
  output logic                pop,
  output imars_pkg::div_req_t div_req,
  input  imars_pkg::div_rsp_t div_rsp,
  imars_out_if.source         stats
);
  import imars_pkg::*;

  localparam logic [2:0] BK_IDLE     = 3'd0;
  localparam logic [2:0] BK_DIV_ACC  = 3'd1;
  localparam logic [2:0] BK_DIV_GAP  = 3'd2;
  localparam logic [2:0] BK_DIV_RESP = 3'd3;
  localparam logic [2:0] BK_OUT      = 3'd4;

  logic [2:0]  state;
  logic        issued;
  snap_t       cur;
  logic [31:0] access_mean_r;
  logic [31:0] gap_mean_r;
  logic [31:0] resp_r;

  logic        rev;
  logic        dividing;
  logic        load;
  logic [31:0] ms_eff;
  logic [63:0] earliest_w;
  logic [63:0] offset_w;
  logic [63:0] delay_w;

  assign rev      = (cur.count > CNT_W_MAX'(1));
  assign dividing = (state == BK_DIV_ACC) || (state == BK_DIV_GAP) ||
                    (state == BK_DIV_RESP);
  assign pop      = (state == BK_IDLE) && !empty;
  assign load     = (state == BK_OUT) && (!stats.valid || stats.ready);

  // A mission length of zero counts as one second.
  assign ms_eff = (cfg.mission_seconds == '0) ? 32'd1 : cfg.mission_seconds;

  // Time to first coverage, clamped at zero.
  assign earliest_w = 64'(cur.earliest);
  assign offset_w   = 64'(cfg.start_offset);
  assign delay_w    = (earliest_w > offset_w) ? earliest_w - offset_w : '0;

  // Operands for the shared divider.
  always_comb begin
    div_req.start = dividing && !issued;
    case (state)
      BK_DIV_GAP: begin
        div_req.dividend = DVD_BITS'(cur.space_total);
        div_req.divisor  = DVS_BITS'(cur.count - 1'b1);
      end
      BK_DIV_RESP: begin
        div_req.dividend = cur.sq_total;
        div_req.divisor  = {ms_eff, 1'b0};
      end
      default: begin
        div_req.dividend = DVD_BITS'(cur.dur_total);
        div_req.divisor  = DVS_BITS'(cur.count);
      end
    endcase
  end

  // Sequencer over the divisions of one run.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= BK_IDLE;
      issued <= 1'b0;
    end else begin
      if (div_req.start) begin
        issued <= 1'b1;
      end
      case (state)
        BK_IDLE: begin
          if (pop) begin
            state <= BK_DIV_ACC;
          end
        end
        BK_DIV_ACC: begin
          if (issued && div_rsp.done) begin
            issued <= 1'b0;
            state  <= rev ? BK_DIV_GAP : BK_OUT;
          end
        end
        BK_DIV_GAP: begin
          if (issued && div_rsp.done) begin
            issued <= 1'b0;
            state  <= BK_DIV_RESP;
          end
        end
        BK_DIV_RESP: begin
          if (issued && div_rsp.done) begin
            issued <= 1'b0;
            state  <= BK_OUT;
          end
        end
        BK_OUT: begin
          if (load) begin
            state <= BK_IDLE;
          end
        end
        default: begin
          state <= BK_IDLE;
        end
      endcase
    end
  end

  // Run snapshot and division results.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_data;
    end
    if (issued && div_rsp.done) begin
      case (state)
        BK_DIV_ACC:  access_mean_r <= sat32(div_rsp.quotient);
        BK_DIV_GAP:  gap_mean_r    <= sat32(div_rsp.quotient);
        BK_DIV_RESP: resp_r        <= sat32(div_rsp.quotient);
        default: begin
        end
      endcase
    end
  end

  // Output register: valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      stats.valid <= 1'b0;
    end else if (load) begin
      stats.valid <= 1'b1;
    end else if (stats.ready) begin
      stats.valid <= 1'b0;
    end
  end

  // Output register: payload.
  always_ff @(posedge clk) begin
    if (load) begin
      stats.merged_count   <= (|cur.count[CNT_W_MAX-1:16]) ? 16'hFFFF : cur.count[15:0];
      stats.coverage_delay <= sat32(delay_w);
      stats.access_min     <= sat32(64'(cur.dur_lo));
      stats.access_max     <= sat32(64'(cur.dur_hi));
      stats.access_mean    <= access_mean_r;
      stats.revisited      <= rev;
      stats.gap_min        <= rev ? sat32(64'(cur.space_lo)) : '0;
      stats.gap_max        <= rev ? sat32(64'(cur.space_hi)) : '0;
      stats.gap_mean       <= rev ? gap_mean_r : '0;
      stats.response_mean  <= rev ? resp_r : '0;
    end
  end

  // The divider is started only while it is free.
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (!stats.valid || stats.ready))
    else $error("output register overwritten");

  // A run without a revisit carries no gap statistics.
  a_no_revisit: assert property (@(posedge clk) disable iff (rst)
    (stats.valid && !stats.revisited) |->
      (stats.gap_mean == '0) && (stats.response_mean == '0) && (stats.gap_max == '0))
    else $error("gap statistics on a run without revisit");

endmodule
